// ===== rtl/core/lmsec_pkg.sv =====
package lmsec_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 16;
    localparam int WEIGHT_W = 24;

    // product widths: weight x sample, (step x error) x sample
    localparam int CONV_W = WEIGHT_W + SAMPLE_W;
    localparam int EX_W   = STEP_W + SAMPLE_W + 1;
    localparam int PROD_W = EX_W + SAMPLE_W;

    // register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_STEP_SIZE = 1'b0;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

endpackage

// ===== rtl/core/lms_adaptive_fir_echo_canceller.sv =====
// channel   | ports                                       | direction
// ----------+---------------------------------------------+----------
// input     | s_valid, s_ready, s_reference_sample,       | in
//           | s_desired_sample                            |
// result    | m_valid, m_ready, m_error_sample            | out
// config    | psel, penable, pwrite, paddr, pwdata,       | in/out
//           | prdata, pready                              |
//
// one transaction at a time: s_ready drops after acceptance until the update pass has drained,
// and m_valid rises once the estimate pass has drained and the error is registered.
// one shared multiplier walks the delay-line and weight memories once for the estimate
// and once more for the weight update, one tap a cycle, each pass draining a 3-stage pipe.
// after reset a clearing pass zeroes both memories; s_ready stays low meanwhile.
// a result waiting on m_ready holds the block before the update pass only.
module lms_adaptive_fir_echo_canceller
    import lmsec_pkg::*;
#(
    parameter int TAPS = 76
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sample_t               s_reference_sample,
    input  sample_t               s_desired_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sample_t               m_error_sample,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W  = CONV_W + PW;
    localparam int DIFF_W = ACC_W + 2;
    localparam logic [PW-1:0] LAST = PW'(TAPS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CONV,
        ST_CONV_WAIT,
        ST_ERR,
        ST_OUT,
        ST_UPD,
        ST_UPD_WAIT
    } state_t;

    state_t state_reg;

    // memories
    sample_t delay_mem [TAPS];
    weight_t w_mem [TAPS];

    logic [PW-1:0] wp_reg;
    logic [PW-1:0] newest_reg;
    logic [PW-1:0] idx_reg;
    logic [PW-1:0] k_reg;
    logic [STEP_W-1:0] step_reg;
    sample_t des_reg;
    sample_t err_reg;
    logic signed [EX_W-1:0] ex_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic m_valid_reg;
    sample_t m_error_reg;

    // pipeline
    logic v1_reg, v2_reg, upd1_reg, upd2_reg;
    logic [PW-1:0] k1_reg, k2_reg;
    sample_t rd_sample_reg;
    weight_t rd_w_reg, w2_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic issue, accept;
    logic signed [EX_W-1:0] mul_a;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [DIFF_W-1:0] diff_rnd;
    logic [DIFF_W-23:0] diff_sh;
    sample_t err_next;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [WEIGHT_W+1:0] w_sum;
    weight_t w_new;
    logic [PW-1:0] idx_step;

    logic dl_we, w_we;
    logic [PW-1:0] dl_waddr, w_waddr;
    sample_t dl_wdata;
    weight_t w_wdata;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign issue          = (state_reg == ST_CONV) || (state_reg == ST_UPD);
    assign m_valid        = m_valid_reg;
    assign m_error_sample = m_error_reg;
    assign idx_step       = (idx_reg == '0) ? LAST : idx_reg - 1'b1;

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_STEP_SIZE) ? APB_DATA_W'(step_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_IDX_STEP_SIZE) begin
            step_reg <= pwdata[STEP_W-1:0];
        end
    end

    // shared multiplier: weight x sample, or (mu x error) x sample
    assign mul_a     = upd1_reg ? ex_reg : EX_W'(rd_w_reg);
    assign prod_next = mul_a * rd_sample_reg;

    // error: round half up to Q1.15 and saturate
    assign diff_rnd = DIFF_W'($signed({des_reg, 1'b1, 21'd0})) - DIFF_W'(acc_reg);
    assign diff_sh  = diff_rnd[DIFF_W-1:22];
    always_comb begin
        if (&diff_sh[DIFF_W-23:15] || ~|diff_sh[DIFF_W-23:15]) begin
            err_next = diff_sh[15:0];
        end else if (diff_sh[DIFF_W-23]) begin
            err_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            err_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // weight update: round half up to Q2.22 and saturate
    assign prod_rnd = prod_reg + PROD_W'(1 << 23);
    assign w_sum    = (WEIGHT_W+2)'(w2_reg) + (WEIGHT_W+2)'($signed(prod_rnd[PROD_W-1:24]));
    always_comb begin
        if (&w_sum[WEIGHT_W+1:WEIGHT_W-1] || ~|w_sum[WEIGHT_W+1:WEIGHT_W-1]) begin
            w_new = w_sum[WEIGHT_W-1:0];
        end else if (w_sum[WEIGHT_W+1]) begin
            w_new = {1'b1, {(WEIGHT_W-1){1'b0}}};
        end else begin
            w_new = {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
    end

    // memory write ports
    assign dl_we    = (state_reg == ST_CLEAR) || accept;
    assign dl_waddr = (state_reg == ST_CLEAR) ? k_reg : wp_reg;
    assign dl_wdata = (state_reg == ST_CLEAR) ? '0 : s_reference_sample;
    assign w_we     = (state_reg == ST_CLEAR) || (v2_reg && upd2_reg);
    assign w_waddr  = (state_reg == ST_CLEAR) ? k_reg : k2_reg;
    assign w_wdata  = (state_reg == ST_CLEAR) ? '0 : w_new;

    always_ff @(posedge aclk) begin
        if (dl_we) begin
            delay_mem[dl_waddr] <= dl_wdata;
        end
        rd_sample_reg <= delay_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem[w_waddr] <= w_wdata;
        end
        rd_w_reg <= w_mem[k_reg];
    end

    // mac pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
        upd1_reg <= (state_reg == ST_UPD);
        upd2_reg <= upd1_reg;
        k1_reg   <= k_reg;
        k2_reg   <= k1_reg;
        w2_reg   <= rd_w_reg;
        prod_reg <= prod_next;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            k_reg       <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            if (v2_reg && !upd2_reg) begin
                acc_reg <= acc_reg + ACC_W'($signed(prod_reg[CONV_W-1:0]));
            end
            case (state_reg)
                ST_CLEAR: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        des_reg    <= s_desired_sample;
                        newest_reg <= wp_reg;
                        idx_reg    <= wp_reg;
                        wp_reg     <= (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
                        k_reg      <= '0;
                        acc_reg    <= '0;
                        state_reg  <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    k_reg   <= k_reg + 1'b1;
                    idx_reg <= idx_step;
                    if (k_reg == LAST) begin
                        state_reg <= ST_CONV_WAIT;
                    end
                end
                ST_CONV_WAIT: begin
                    if (!v1_reg && !v2_reg) begin
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    err_reg   <= err_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_error_reg <= err_reg;
                        m_valid_reg <= 1'b1;
                        ex_reg      <= $signed({1'b0, step_reg}) * err_reg;
                        idx_reg     <= newest_reg;
                        k_reg       <= '0;
                        state_reg   <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    k_reg   <= k_reg + 1'b1;
                    idx_reg <= idx_step;
                    if (k_reg == LAST) begin
                        state_reg <= ST_UPD_WAIT;
                    end
                end
                ST_UPD_WAIT: begin
                    if (!v1_reg && !v2_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/lmsec_checker.sv =====
module lmsec_checker
    import lmsec_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input sample_t               s_reference_sample,
    input sample_t               s_desired_sample,
    input logic                  m_valid,
    input logic                  m_ready,
    input sample_t               m_error_sample,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_error_sample))
        else $error("result changed while stalled");

    // reset starts the clearing pass, no input taken right after
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    // one transaction at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after acceptance");

    // a result cannot appear in the cycle after an input is taken
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind lms_adaptive_fir_echo_canceller lmsec_checker u_lmsec_checker (.*);

// ===== tb/sv/lmsec_error_checker.sv =====
module lmsec_error_checker
    import lmsec_pkg::*;
#(
    parameter int TAPS = 76
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  sample_t               s_reference_sample,
    input  sample_t               s_desired_sample,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  sample_t               m_error_sample,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  wrap_up,
    output int                    mismatches
);

    // rounding offsets and saturation bounds
    localparam longint EST_HALF = longint'(1) <<< 21;
    localparam longint UPD_HALF = longint'(1) <<< 23;
    localparam longint ERR_HI   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint ERR_LO   = -(longint'(1) <<< (SAMPLE_W - 1));
    localparam longint WGT_HI   = (longint'(1) <<< (WEIGHT_W - 1)) - 1;
    localparam longint WGT_LO   = -(longint'(1) <<< (WEIGHT_W - 1));

    // shadow copy of the filter state
    sample_t           ring [TAPS];
    weight_t           weights [TAPS];
    int                head;
    logic [STEP_W-1:0] mu;

    sample_t           pending_errors [$];
    int                result_idx;
    bit                leftover_checked;

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, result_idx, msg);
        mismatches++;
    endtask

    // one lms step: estimate with old weights, saturate error, then adapt
    function automatic sample_t cancel_echo(input sample_t ref_s, input sample_t des_s);
        longint est;
        longint diff;
        longint err;
        longint scaled;
        longint upd;
        longint w;
        int     slot;
        int     k;
        est = 0;
        ring[head] = ref_s;
        slot = head;
        head = (head == TAPS - 1) ? 0 : head + 1;
        for (k = 0; k < TAPS; k++) begin
            est += longint'(weights[k]) * longint'(ring[slot]);
            slot = (slot == 0) ? TAPS - 1 : slot - 1;
        end
        diff = (longint'(des_s) <<< 22) - est;
        err = (diff + EST_HALF) >>> 22;
        if (err > ERR_HI) err = ERR_HI;
        if (err < ERR_LO) err = ERR_LO;

        // the saturated error drives adaptation
        scaled = longint'(mu) * err;
        slot = (head == 0) ? TAPS - 1 : head - 1;
        for (k = 0; k < TAPS; k++) begin
            upd = (scaled * longint'(ring[slot]) + UPD_HALF) >>> 24;
            w = longint'(weights[k]) + upd;
            if (w > WGT_HI) w = WGT_HI;
            if (w < WGT_LO) w = WGT_LO;
            weights[k] = w[WEIGHT_W-1:0];
            slot = (slot == 0) ? TAPS - 1 : slot - 1;
        end
        return err[SAMPLE_W-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        int      k;
        sample_t want;
        if (!aresetn) begin
            for (k = 0; k < TAPS; k++) begin
                ring[k] = '0;
                weights[k] = '0;
            end
            head = 0;
            mu = STEP_RESET;
            pending_errors.delete();
            result_idx = 0;
            leftover_checked = 1'b0;
        end else begin
            // result transaction: compare with oldest prediction
            if (m_valid && m_ready) begin
                if (pending_errors.size() == 0) begin
                    report_mismatch($sformatf("unexpected error_sample %0d", m_error_sample));
                end else begin
                    want = pending_errors.pop_front();
                    if (m_error_sample !== want)
                        report_mismatch($sformatf("error_sample %0d, predicted %0d",
                                                  m_error_sample, want));
                end
                result_idx++;
            end

            // input transaction: predict its error sample
            if (s_valid && s_ready)
                pending_errors.push_back(cancel_echo(s_reference_sample, s_desired_sample));

            // register write, other indexes are ignored
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_IDX_STEP_SIZE)
                mu = pwdata[STEP_W-1:0];

            // predictions still open at the end
            if (wrap_up && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (pending_errors.size() != 0)
                    report_mismatch($sformatf("%0d error samples never arrived",
                                              pending_errors.size()));
            end
        end
    end

endmodule

// ===== tb/sv/lms_adaptive_fir_echo_canceller_tb.sv =====
module lms_adaptive_fir_echo_canceller_tb;
    import lmsec_pkg::*;

    localparam int TAPS            = 76;
    localparam int REG_IDX_UNUSED  = 1;
    localparam int PHASES          = 7;
    localparam int PHASE_ITEMS     = 100;
    localparam int CORNERS         = 14;

    localparam logic [APB_ADDR_W-1:0] ADDR_STEP   = APB_ADDR_W'(4 * REG_IDX_STEP_SIZE);
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = APB_ADDR_W'(4 * REG_IDX_UNUSED);

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    sample_t               s_reference_sample;
    sample_t               s_desired_sample;
    logic                  m_valid;
    logic                  m_ready;
    sample_t               m_error_sample;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  wrap_up;
    int                    mismatches;

    int                    sent_count;
    int                    recv_count;
    bit                    steady;
    sample_t               ref_history [0:7];

    // corner samples, run at the reset step size
    sample_t corner_ref [0:CORNERS-1] = '{0, 32767, -32768, 32767, -32768, 1, -1,
                                          0, 21845, -21846, 32767, 32767, -32768, 0};
    sample_t corner_des [0:CORNERS-1] = '{0, 32767, -32768, -32768, 32767, -1, 1,
                                          32767, -21846, 21845, 0, -32768, 0, -32768};

    lms_adaptive_fir_echo_canceller #(
        .TAPS(TAPS)
    ) uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_reference_sample (s_reference_sample),
        .s_desired_sample   (s_desired_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_error_sample     (m_error_sample),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    lmsec_error_checker #(
        .TAPS(TAPS)
    ) checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_reference_sample (s_reference_sample),
        .s_desired_sample   (s_desired_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_error_sample     (m_error_sample),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .wrap_up            (wrap_up),
        .mismatches         (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        #6000000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stall after each transaction, none in steady phases
    always @(posedge aclk) begin : result_side
        int stall;
        int rx_wait;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
            recv_count <= 0;
        end else if (m_valid && m_ready) begin
            recv_count <= recv_count + 1;
            stall = steady ? 0 : $urandom_range(0, 5);
            rx_wait = stall;
            m_ready <= (stall == 0);
        end else if (rx_wait != 0) begin
            rx_wait = rx_wait - 1;
            m_ready <= (rx_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one input transaction, valid kept high across back-to-back items
    task automatic send_sample(input sample_t ref_s, input sample_t des_s);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_reference_sample <= ref_s;
        s_desired_sample <= des_s;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sent_count++;
    endtask

    // wait until every result is back and the update pass is over
    task automatic quiesce();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (recv_count != sent_count || !s_ready);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // mostly echo-like sequences, some full-range noise and extremes
    task automatic make_sample(output sample_t ref_s, output sample_t des_s);
        int              pick;
        int              echo;
        logic [31:0]     bits;
        pick = $urandom_range(0, 99);
        bits = $urandom;
        if (pick < 60) begin
            ref_s = (pick < 20) ? sample_t'(bits[15:0]) : sample_t'($signed(bits[15:0]) >>> 3);
            echo = (int'(ref_history[3]) >>> 1) + (int'(ref_history[6]) >>> 3)
                   + $urandom_range(0, 63) - 32;
            des_s = sample_t'(echo);
        end else if (pick < 85) begin
            ref_s = bits[15:0];
            des_s = bits[31:16];
        end else begin
            case ($urandom_range(0, 4))
                0: ref_s = 16'sh7fff;
                1: ref_s = 16'sh8000;
                2: ref_s = '0;
                3: ref_s = -16'sd1;
                default: ref_s = bits[15:0];
            endcase
            des_s = bits[16] ? 16'sh7fff : (bits[17] ? 16'sh8000 : sample_t'(bits[31:16]));
        end
        for (int i = 7; i > 0; i--) ref_history[i] = ref_history[i-1];
        ref_history[0] = ref_s;
    endtask

    initial begin : stimulus
        sample_t           r;
        sample_t           d;
        logic [STEP_W-1:0] mu;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_reference_sample <= '0;
        s_desired_sample <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        wrap_up <= 1'b0;
        steady = 1'b0;
        sent_count = 0;
        foreach (ref_history[i]) ref_history[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // corners at the reset step size
        for (int i = 0; i < CORNERS; i++) send_sample(corner_ref[i], corner_des[i]);

        // full step size, upper data bits must be ignored: drive weights into saturation
        quiesce();
        write_reg(ADDR_STEP, 32'hA5A5_FFFF);
        repeat (4) send_sample(16'sh7fff, 16'sh7fff);
        repeat (2) send_sample(16'sh7fff, 16'sh8000);
        repeat (2) send_sample(16'sh8000, 16'sh7fff);

        // write to an unmapped index, step size must stay
        quiesce();
        write_reg(ADDR_UNUSED, 32'h0000_0000);
        send_sample(16'sh4000, 16'sh8000);

        // random phases over several step sizes
        for (int phase = 0; phase < PHASES; phase++) begin
            quiesce();
            case (phase)
                0: mu = 16'd1;
                1: mu = 16'd0;
                2: mu = 16'hFFFF;
                3: mu = STEP_RESET;
                4: mu = STEP_W'($urandom_range(1, 4096));
                5: mu = 16'd8192;
                default: mu = STEP_W'($urandom);
            endcase
            write_reg(ADDR_STEP, {16'($urandom), mu});
            steady = (phase == 1) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                make_sample(r, d);
                send_sample(r, d);
            end
        end

        quiesce();
        steady = 1'b0;
        repeat (20) @(posedge aclk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
